@@ rtl/gugn_pkg.sv @@
// Shared widths, register codes, pipeline types and the upwind magnitude helper.
package gugn_pkg;

    localparam int DATA_W = 32;
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;
    localparam int REM_W  = 34;
    localparam int DIM_W  = 2;

    localparam logic [DIM_W-1:0] DIM_NONE  = 2'd0;
    localparam logic [DIM_W-1:0] DIM_ONE   = 2'd1;
    localparam logic [DIM_W-1:0] DIM_TWO   = 2'd2;
    localparam logic [DIM_W-1:0] DIM_THREE = 2'd3;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_THREE;

    // One stage of the square-root chain.
    typedef struct packed {
        logic                valid;
        logic [SUM_W-1:0]    radicand;
        logic [REM_W-1:0]    rem;
        logic [ROOT_W-1:0]   root;
    } t_sqrt_stage;

    // Larger of the two one-sided magnitudes that the upwind choice keeps.
    function automatic logic [DATA_W-1:0] f_upwind_mag(
        input logic               positive,
        input logic signed [DATA_W-1:0] left_g,
        input logic signed [DATA_W-1:0] right_g
    );
        logic [DATA_W-1:0] l_pos;
        logic [DATA_W-1:0] l_neg;
        logic [DATA_W-1:0] r_pos;
        logic [DATA_W-1:0] r_neg;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        l_pos = (!left_g[DATA_W-1] && (left_g != '0)) ? DATA_W'(left_g) : '0;
        l_neg = left_g[DATA_W-1] ? DATA_W'(-left_g) : '0;
        r_pos = (!right_g[DATA_W-1] && (right_g != '0)) ? DATA_W'(right_g) : '0;
        r_neg = right_g[DATA_W-1] ? DATA_W'(-right_g) : '0;
        a = positive ? l_neg : l_pos;
        b = positive ? r_pos : r_neg;
        return (a > b) ? a : b;
    endfunction

endpackage

@@ rtl/gugn_front.sv @@
// Upwind selection, per-direction squaring and the sum of squares, three registered stages.
module gugn_front import gugn_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic [DIM_W-1:0]         i_dimension,
    input  logic signed [DATA_W-1:0] i_level_set_value,
    input  logic signed [DATA_W-1:0] i_left_grad_x,
    input  logic signed [DATA_W-1:0] i_right_grad_x,
    input  logic signed [DATA_W-1:0] i_left_grad_y,
    input  logic signed [DATA_W-1:0] i_right_grad_y,
    input  logic signed [DATA_W-1:0] i_left_grad_z,
    input  logic signed [DATA_W-1:0] i_right_grad_z,
    output logic                     o_valid,
    output logic [SUM_W-1:0]         o_sum
);

    logic              positive;
    logic              en_y;
    logic              en_z;
    logic [DATA_W-1:0] n_mag_x;
    logic [DATA_W-1:0] n_mag_y;
    logic [DATA_W-1:0] n_mag_z;

    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic [DATA_W-1:0] r_mag_x;
    logic [DATA_W-1:0] r_mag_y;
    logic [DATA_W-1:0] r_mag_z;
    logic [SUM_W-1:0]  r_sq_x;
    logic [SUM_W-1:0]  r_sq_y;
    logic [SUM_W-1:0]  r_sq_z;
    logic [SUM_W-1:0]  r_sum;

    always_comb begin
        positive = !i_level_set_value[DATA_W-1] && (i_level_set_value != '0);
        case (i_dimension)
            DIM_NONE:  begin en_y = 1'b0; en_z = 1'b0; end
            DIM_ONE:   begin en_y = 1'b0; en_z = 1'b0; end
            DIM_TWO:   begin en_y = 1'b1; en_z = 1'b0; end
            DIM_THREE: begin en_y = 1'b1; en_z = 1'b1; end
            default:   begin en_y = 1'b0; en_z = 1'b0; end
        endcase
        n_mag_x = f_upwind_mag(positive, i_left_grad_x, i_right_grad_x);
        // drop unused directions here so the squares below come out zero
        n_mag_y = en_y ? f_upwind_mag(positive, i_left_grad_y, i_right_grad_y) : '0;
        n_mag_z = en_z ? f_upwind_mag(positive, i_left_grad_z, i_right_grad_z) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag_x <= n_mag_x;
        r_mag_y <= n_mag_y;
        r_mag_z <= n_mag_z;
        r_sq_x  <= SUM_W'(r_mag_x) * SUM_W'(r_mag_x);
        r_sq_y  <= SUM_W'(r_mag_y) * SUM_W'(r_mag_y);
        r_sq_z  <= SUM_W'(r_mag_z) * SUM_W'(r_mag_z);
        // each square is at most 2^62, so three fit in the sum width
        r_sum   <= r_sq_x + r_sq_y + r_sq_z;
    end

    assign o_valid = r_v3;
    assign o_sum   = r_sum;

endmodule

@@ rtl/gugn_sqrt_cell.sv @@
// One digit of the restoring square root: brings down two radicand bits, decides one root bit.
module gugn_sqrt_cell import gugn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sqrt_stage i_stage,
    output t_sqrt_stage o_stage
);

    logic [REM_W+1:0] shifted;
    logic [REM_W+1:0] trial;
    logic             take;
    t_sqrt_stage      n_stage;
    t_sqrt_stage      r_stage;

    always_comb begin
        shifted = {i_stage.rem, i_stage.radicand[SUM_W-1 -: 2]};
        trial   = (REM_W+2)'({i_stage.root, 2'b01});
        take    = (shifted >= trial);
        n_stage.valid    = i_stage.valid;
        n_stage.radicand = {i_stage.radicand[SUM_W-3:0], 2'b00};
        n_stage.rem      = take ? REM_W'(shifted - trial) : REM_W'(shifted);
        n_stage.root     = {i_stage.root[ROOT_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        r_stage.radicand <= n_stage.radicand;
        r_stage.rem      <= n_stage.rem;
        r_stage.root     <= n_stage.root;
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= n_stage.valid;
        end
    end

    assign o_stage = r_stage;

endmodule

@@ rtl/godunov_upwind_gradient_norm_unit.sv @@
// Top level of the Godunov upwind gradient magnitude unit.
//
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+----------------------------
//  command  | start, busy, i_level_set_value, i_*_grad_* | taken when start && !busy
//  result   | o_done, o_gradient_magnitude             | one-cycle strobe, no stall
//  config   | i_cfg_wr_en, i_cfg_wr_data (dimension)   | written when i_cfg_wr_en
//
// One node enters per cycle; busy is always low. Each node passes three front stages
// (select, square, sum) and then one cell per root bit in the 32-cell square-root
// chain. Reset clears the dimension register to 3 and every valid flag in the
// pipeline. The receiver cannot stall, so the chain advances every cycle.
module godunov_upwind_gradient_norm_unit import gugn_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] i_level_set_value,
    input  logic signed [DATA_W-1:0] i_left_grad_x,
    input  logic signed [DATA_W-1:0] i_right_grad_x,
    input  logic signed [DATA_W-1:0] i_left_grad_y,
    input  logic signed [DATA_W-1:0] i_right_grad_y,
    input  logic signed [DATA_W-1:0] i_left_grad_z,
    input  logic signed [DATA_W-1:0] i_right_grad_z,
    input  logic                     i_cfg_wr_en,
    input  logic [DIM_W-1:0]         i_cfg_wr_data,
    output logic                     o_done,
    output logic [ROOT_W-1:0]        o_gradient_magnitude
);

    localparam int LATENCY = 3 + ROOT_W;

    logic [DIM_W-1:0] r_dimension;
    logic             accept;
    logic             sum_valid;
    logic [SUM_W-1:0] sum;
    t_sqrt_stage      w_chain [0:ROOT_W];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dimension <= DIM_RESET;
        end else if (i_cfg_wr_en) begin
            r_dimension <= i_cfg_wr_data;
        end
    end

    gugn_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (accept),
        .i_dimension       (r_dimension),
        .i_level_set_value (i_level_set_value),
        .i_left_grad_x     (i_left_grad_x),
        .i_right_grad_x    (i_right_grad_x),
        .i_left_grad_y     (i_left_grad_y),
        .i_right_grad_y    (i_right_grad_y),
        .i_left_grad_z     (i_left_grad_z),
        .i_right_grad_z    (i_right_grad_z),
        .o_valid           (sum_valid),
        .o_sum             (sum)
    );

    assign w_chain[0] = '{valid: sum_valid, radicand: sum, rem: '0, root: '0};

    for (genvar g = 0; g < ROOT_W; g++) begin : g_cell
        gugn_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    assign o_done               = w_chain[ROOT_W].valid;
    assign o_gradient_magnitude = w_chain[ROOT_W].root;

    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("accepted transaction did not complete on time");

    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LATENCY))
        else $error("result strobe without a matching transaction");

    a_root_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (SUM_W'(o_gradient_magnitude) * SUM_W'(o_gradient_magnitude))
                   <= $past(sum, ROOT_W))
        else $error("root too large");

    a_root_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((SUM_W+2)'(o_gradient_magnitude) + 1) *
                   ((SUM_W+2)'(o_gradient_magnitude) + 1) > (SUM_W+2)'($past(sum, ROOT_W)))
        else $error("root too small");

endmodule
